### sv/mrpt_pkg.sv
// shared constants, types and the base table of the primality tester
`default_nettype none

package mrpt_pkg;

   localparam int VALUE_WIDTH_DEF = 64;
   localparam int BASE_COUNT_DEF  = 10;
   localparam int NUM_BASES       = 10;
   localparam int BASE_IDX_W      = 4;
   localparam int BASE_W          = 5;
   localparam int RSP_W           = 8;

   // witness bases, the first ten primes
   function automatic logic [BASE_W-1:0] base_value(input logic [BASE_IDX_W-1:0] idx);
      logic [BASE_W-1:0] val;
      case (idx)
         4'd0:    val = 5'd2;
         4'd1:    val = 5'd3;
         4'd2:    val = 5'd5;
         4'd3:    val = 5'd7;
         4'd4:    val = 5'd11;
         4'd5:    val = 5'd13;
         4'd6:    val = 5'd17;
         4'd7:    val = 5'd19;
         4'd8:    val = 5'd23;
         4'd9:    val = 5'd29;
         default: val = 5'd2;
      endcase
      return val;
   endfunction

   typedef enum logic [1:0] {
      MUL_BASE,
      MUL_RX,
      MUL_SQR
   } mul_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_STRIP,
      ST_BASE,
      ST_WAIT_BASE,
      ST_EXP,
      ST_WAIT_R,
      ST_EXP_SQ,
      ST_WAIT_SQ,
      ST_CHECK,
      ST_WIT,
      ST_WAIT_W,
      ST_NEXT,
      ST_DONE_PRIME,
      ST_DONE_COMP
   } state_type;

   typedef struct packed {
      logic       load;
      logic       strip;
      logic       base_init;
      logic       mul_start;
      mul_op_type mul_op;
      logic       e_shift;
      logic       wr_x;
      logic       wr_r;
      logic       copy_rx;
      logic       k_inc;
      logic       next_base;
      logic       finish;
      logic       verdict;
   } cmd_type;

   typedef struct packed {
      logic n_lt2;
      logic d_lsb;
      logic n_eq_base;
      logic e_zero;
      logic e_lsb;
      logic x_one;
      logic x_nm1;
      logic prod_one;
      logic k_done;
      logic base_last;
      logic mul_done;
   } status_type;

endpackage

`default_nettype wire

### sv/miller_rabin_prime_test.sv
// top level of the deterministic miller-rabin primality tester
//
//   channel | dir | handshake              | payload
//   --------+-----+------------------------+-------------------------------------
//   req     | in  | req_tvalid/req_tready  | req_tdata: candidate (low VALUE_WIDTH bits)
//   rsp     | out | rsp_tvalid/rsp_tready  | rsp_tdata: is_prime in bit 0
//
// one candidate at a time
// time is set by the bit-serial modular multiplier: one multiplier bit per cycle,
//   up to two products per exponent bit, ten bases
// 0 and 1 are rejected and 2 is found prime before any product; a candidate equal to
//   a later base first runs the rounds of the smaller bases, with short products
// synchronous active-high reset returns the controller to idle and empties the output
// the result register lets a new candidate enter while the last answer waits on rsp_tready
`default_nettype none

module miller_rabin_prime_test import mrpt_pkg::*; #(
   parameter int  VALUE_WIDTH = VALUE_WIDTH_DEF,
   parameter int  BASE_COUNT  = BASE_COUNT_DEF,
   localparam int REQ_W       = ((VALUE_WIDTH + 7) / 8) * 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [REQ_W-1:0] req_tdata,   // [VALUE_WIDTH-1:0] candidate, rest zero
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata    // [0] is_prime, rest zero
);

   cmd_type    cmd;
   status_type status;
   logic       out_free;

   // output word register
   logic rsp_valid_ff, rsp_valid_in;
   logic is_prime_ff, is_prime_in;

   // answer may be written when the slot is empty or being drained
   assign out_free = !rsp_valid_ff || rsp_tready;

   mrpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .out_free  (out_free),
      .status    (status),
      .ready     (req_tready),
      .cmd       (cmd)
   );

   mrpt_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .BASE_COUNT  (BASE_COUNT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .candidate (req_tdata[VALUE_WIDTH-1:0]),
      .cmd       (cmd),
      .status    (status)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      is_prime_in  = is_prime_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         is_prime_in  = cmd.verdict;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      is_prime_ff <= is_prime_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W-1){1'b0}}, is_prime_ff};

endmodule

`default_nettype wire

### sv/mrpt_mulmod.sv
// bit-serial shift-and-add modular multiplier, one multiplier bit per cycle
`default_nettype none

module mrpt_mulmod import mrpt_pkg::*; #(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [VALUE_WIDTH-1:0] a,      // must be below m
   input  wire logic [VALUE_WIDTH-1:0] b,
   input  wire logic [VALUE_WIDTH-1:0] m,
   output logic                        done,
   output logic [VALUE_WIDTH-1:0]      result
);

   logic                   busy_ff, busy_in;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic [VALUE_WIDTH-1:0] dbl_ff, dbl_in;
   logic [VALUE_WIDTH-1:0] mlt_ff, mlt_in;

   logic [VALUE_WIDTH:0] m_ext;
   logic [VALUE_WIDTH:0] sum_acc, sum_dbl;
   logic [VALUE_WIDTH:0] red_acc, red_dbl;

   always_comb begin
      m_ext   = {1'b0, m};
      // sums keep their carry so nothing wraps
      sum_acc = {1'b0, acc_ff} + {1'b0, dbl_ff};
      sum_dbl = {1'b0, dbl_ff} + {1'b0, dbl_ff};
      red_acc = (sum_acc >= m_ext) ? sum_acc - m_ext : sum_acc;
      red_dbl = (sum_dbl >= m_ext) ? sum_dbl - m_ext : sum_dbl;

      done    = busy_ff && (mlt_ff == '0);
      result  = acc_ff;

      busy_in = busy_ff;
      acc_in  = acc_ff;
      dbl_in  = dbl_ff;
      mlt_in  = mlt_ff;
      if (start) begin
         busy_in = 1'b1;
         acc_in  = '0;
         dbl_in  = a;
         mlt_in  = b;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (busy_ff) begin
         if (mlt_ff[0]) begin
            acc_in = red_acc[VALUE_WIDTH-1:0];
         end
         dbl_in = red_dbl[VALUE_WIDTH-1:0];
         mlt_in = mlt_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      dbl_ff <= dbl_in;
      mlt_ff <= mlt_in;
   end

endmodule

`default_nettype wire

### sv/mrpt_datapath.sv
// datapath: candidate, odd part, exponent, running values and the multiplier
`default_nettype none

module mrpt_datapath import mrpt_pkg::*; #(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
   parameter int BASE_COUNT  = BASE_COUNT_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [VALUE_WIDTH-1:0] candidate,
   input  wire cmd_type                cmd,
   output status_type                  status
);

   localparam int TW = $clog2(VALUE_WIDTH);
   localparam logic [VALUE_WIDTH-1:0] ONE = VALUE_WIDTH'(1);

   logic [VALUE_WIDTH-1:0] n_ff, n_in;
   logic [VALUE_WIDTH-1:0] nm1_ff, nm1_in;
   logic [VALUE_WIDTH-1:0] d_ff, d_in;
   logic [VALUE_WIDTH-1:0] e_ff, e_in;
   logic [VALUE_WIDTH-1:0] x_ff, x_in;
   logic [VALUE_WIDTH-1:0] r_ff, r_in;
   logic [TW-1:0]          twos_ff, twos_in;
   logic [TW-1:0]          k_ff, k_in;
   logic [BASE_IDX_W-1:0]  idx_ff, idx_in;

   logic [VALUE_WIDTH-1:0] base_ext;
   logic [VALUE_WIDTH-1:0] mul_a, mul_b;
   logic [VALUE_WIDTH-1:0] prod;
   logic                   mul_done;

   mrpt_mulmod #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_mulmod (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.mul_start),
      .a      (mul_a),
      .b      (mul_b),
      .m      (n_ff),
      .done   (mul_done),
      .result (prod)
   );

   always_comb begin
      base_ext = {{(VALUE_WIDTH-BASE_W){1'b0}}, base_value(idx_ff)};

      // base is fed as the multiplier bits, so it needs no prior reduction
      case (cmd.mul_op)
         MUL_BASE: begin
            mul_a = ONE;
            mul_b = base_ext;
         end
         MUL_RX: begin
            mul_a = r_ff;
            mul_b = x_ff;
         end
         MUL_SQR: begin
            mul_a = x_ff;
            mul_b = x_ff;
         end
         default: begin
            mul_a = x_ff;
            mul_b = x_ff;
         end
      endcase

      n_in    = n_ff;
      nm1_in  = nm1_ff;
      d_in    = d_ff;
      e_in    = e_ff;
      x_in    = x_ff;
      r_in    = r_ff;
      twos_in = twos_ff;
      k_in    = k_ff;
      idx_in  = idx_ff;

      if (cmd.load) begin
         n_in    = candidate;
         nm1_in  = candidate - ONE;
         d_in    = candidate - ONE;
         twos_in = '0;
         idx_in  = '0;
      end
      if (cmd.strip) begin
         d_in    = d_ff >> 1;
         twos_in = twos_ff + TW'(1);
      end
      if (cmd.base_init) begin
         e_in = d_ff;
         r_in = ONE;
      end
      if (cmd.e_shift) begin
         e_in = e_ff >> 1;
      end
      if (cmd.wr_x) begin
         x_in = prod;
      end
      if (cmd.wr_r) begin
         r_in = prod;
      end
      if (cmd.copy_rx) begin
         x_in = r_ff;
         k_in = '0;
      end
      if (cmd.k_inc) begin
         k_in = k_ff + TW'(1);
      end
      if (cmd.next_base) begin
         idx_in = idx_ff + BASE_IDX_W'(1);
      end

      status.n_lt2     = (n_ff[VALUE_WIDTH-1:1] == '0);
      status.d_lsb     = d_ff[0];
      status.n_eq_base = (n_ff == base_ext);
      status.e_zero    = (e_ff == '0);
      status.e_lsb     = e_ff[0];
      status.x_one     = (x_ff == ONE);
      status.x_nm1     = (x_ff == nm1_ff);
      status.prod_one  = (prod == ONE);
      status.k_done    = (k_ff == twos_ff);
      status.base_last = (idx_ff == BASE_IDX_W'(BASE_COUNT - 1));
      status.mul_done  = mul_done;
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      nm1_ff  <= nm1_in;
      d_ff    <= d_in;
      e_ff    <= e_in;
      x_ff    <= x_in;
      r_ff    <= r_in;
      twos_ff <= twos_in;
      k_ff    <= k_in;
      idx_ff  <= idx_in;
   end

endmodule

`default_nettype wire

### sv/mrpt_ctrl.sv
// controller state machine sequencing the miller-rabin rounds
`default_nettype none

module mrpt_ctrl import mrpt_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       out_free,
   input  wire status_type status,
   output logic            ready,
   output cmd_type         cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_STRIP;
            end
         end
         ST_STRIP: begin
            if (status.n_lt2) begin
               state_in = ST_DONE_COMP;
            end else if (!status.d_lsb) begin
               cmd.strip = 1'b1;
            end else begin
               state_in = ST_BASE;
            end
         end
         ST_BASE: begin
            if (status.n_eq_base) begin
               state_in = ST_DONE_PRIME;
            end else begin
               cmd.mul_start = 1'b1;
               cmd.mul_op    = MUL_BASE;
               cmd.base_init = 1'b1;
               state_in      = ST_WAIT_BASE;
            end
         end
         ST_WAIT_BASE: begin
            if (status.mul_done) begin
               cmd.wr_x = 1'b1;
               state_in = ST_EXP;
            end
         end
         ST_EXP: begin
            if (status.e_zero || status.x_one) begin
               state_in = ST_CHECK;
            end else if (status.e_lsb) begin
               cmd.mul_start = 1'b1;
               cmd.mul_op    = MUL_RX;
               state_in      = ST_WAIT_R;
            end else begin
               state_in = ST_EXP_SQ;
            end
         end
         ST_WAIT_R: begin
            if (status.mul_done) begin
               cmd.wr_r = 1'b1;
               state_in = ST_EXP_SQ;
            end
         end
         ST_EXP_SQ: begin
            cmd.mul_start = 1'b1;
            cmd.mul_op    = MUL_SQR;
            cmd.e_shift   = 1'b1;
            state_in      = ST_WAIT_SQ;
         end
         ST_WAIT_SQ: begin
            if (status.mul_done) begin
               cmd.wr_x = 1'b1;
               state_in = ST_EXP;
            end
         end
         ST_CHECK: begin
            cmd.copy_rx = 1'b1;
            state_in    = ST_WIT;
         end
         ST_WIT: begin
            if (status.x_one) begin
               state_in = ST_NEXT;
            end else if (status.k_done) begin
               state_in = ST_DONE_COMP;
            end else begin
               cmd.mul_start = 1'b1;
               cmd.mul_op    = MUL_SQR;
               state_in      = ST_WAIT_W;
            end
         end
         ST_WAIT_W: begin
            if (status.mul_done) begin
               if (status.prod_one) begin
                  // a nontrivial square root of one means composite
                  state_in = status.x_nm1 ? ST_NEXT : ST_DONE_COMP;
               end else begin
                  cmd.wr_x  = 1'b1;
                  cmd.k_inc = 1'b1;
                  state_in  = ST_WIT;
               end
            end
         end
         ST_NEXT: begin
            if (status.base_last) begin
               state_in = ST_DONE_PRIME;
            end else begin
               cmd.next_base = 1'b1;
               state_in      = ST_BASE;
            end
         end
         ST_DONE_PRIME: begin
            if (out_free) begin
               cmd.finish  = 1'b1;
               cmd.verdict = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_DONE_COMP: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### sv/mrpt_checker.sv
// port-level checker for the primality tester and its bind
`default_nettype none

module mrpt_checker import mrpt_pkg::*; (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_tvalid,
   input wire logic             req_tready,
   input wire logic             rsp_tvalid,
   input wire logic             rsp_tready,
   input wire logic [RSP_W-1:0] rsp_tdata
);

   // result slot is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // a waiting answer holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled rsp word changed");

   // only bit 0 carries the verdict
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_W-1:1] == '0)
      else $error("rsp_tdata padding not zero");

   // one candidate in flight: busy the cycle after a word is taken
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req taken while a candidate is in progress");

endmodule

bind miller_rabin_prime_test mrpt_checker u_mrpt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

### sim/miller_rabin_prime_test_tb.sv
// self-checking testbench for the miller-rabin primality tester: stream stimulus, verdict check
module miller_rabin_prime_test_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mrpt_pkg::*;

   localparam int VALUE_WIDTH  = 64;
   localparam int BASE_COUNT   = 10;
   localparam int REQ_W        = ((VALUE_WIDTH + 7) / 8) * 8;
   localparam int RANDOM_WORDS = 77;

   // limit on the run: about 100 words at the worst case each, plus the longest sender gap and
   // receiver stall per word, with a margin of about four times that sum
   localparam longint CYCLE_LIMIT = 40_000_000;

   // largest prime below 2^64, keeps the prime search from running past the top
   localparam logic [63:0] LARGEST_PRIME = 64'hFFFF_FFFF_FFFF_FFC5;

   // witness bases in trial order, entry 0 first
   localparam int BASE_LIST_LEN = 10;
   localparam logic [BASE_LIST_LEN-1:0][4:0] TRIAL_BASES =
      {5'd29, 5'd23, 5'd19, 5'd17, 5'd13, 5'd11, 5'd7, 5'd5, 5'd3, 5'd2};

   // receiver behavior, switched at random intervals
   typedef enum logic [1:0] {
      RX_STREAM,   // always ready
      RX_JITTER,   // short random stalls
      RX_STALL     // rare long stalls
   } rx_mode_type;

   // one pending candidate; drain_first holds it back until every verdict is in
   typedef struct packed {
      logic [VALUE_WIDTH-1:0] value;
      logic                   drain_first;
   } candidate_word_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_W-1:0]       req_tdata = '0;   // [63:0] candidate
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_W-1:0]       rsp_tdata;        // [0] is_prime, [7:1] zero

   candidate_word_type     candidate_q[$];   // words not yet offered
   logic                   verdict_q[$];     // expected is_prime per accepted candidate
   int                     verdicts_due = 0; // mirror of the verdict queue depth, for the driver
   int                     mismatches = 0;
   longint                 cycle_count = 0;

   // sender burst shaping
   int                     burst_left = 0;
   int                     gap_left = 0;

   // receiver stall shaping
   rx_mode_type            rx_mode = RX_STREAM;
   int                     rx_mode_left = 0;
   int                     stall_left = 0;

   miller_rabin_prime_test #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .BASE_COUNT  (BASE_COUNT)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------------
   // verdict prediction: shift-and-add modular arithmetic with 65-bit sums
   // ---------------------------------------------------------------------------------------

   // (a + b) mod m for a, b < m; the carry out of bit 63 is kept
   function automatic logic [63:0] mod_sum(input logic [63:0] a, input logic [63:0] b,
                                           input logic [63:0] m);
      logic [64:0] total;
      total = {1'b0, a} + {1'b0, b};
      if (total >= {1'b0, m}) total = total - {1'b0, m};
      return total[63:0];
   endfunction

   // (a * b) mod m, one multiplier bit per step
   function automatic logic [63:0] mod_product(input logic [63:0] a, input logic [63:0] b,
                                               input logic [63:0] m);
      logic [63:0] acc;
      logic [63:0] addend;
      logic [63:0] bits;
      acc    = '0;
      addend = a % m;
      bits   = b;
      while (bits != 0) begin
         if (bits[0]) acc = mod_sum(acc, addend, m);
         addend = mod_sum(addend, addend, m);
         bits   = bits >> 1;
      end
      return acc;
   endfunction

   // base^expo mod m; stops as soon as the running square is one (base left unreduced)
   function automatic logic [63:0] mod_power(input logic [63:0] base, input logic [63:0] expo,
                                             input logic [63:0] m);
      logic [63:0] acc;
      logic [63:0] sq;
      logic [63:0] e;
      acc = 64'd1;
      sq  = base;
      e   = expo;
      while (e != 0 && sq != 64'd1) begin
         if (e[0]) acc = mod_product(acc, sq, m);
         e  = e >> 1;
         sq = mod_product(sq, sq, m);
      end
      return acc;
   endfunction

   function automatic logic primality_verdict(input logic [VALUE_WIDTH-1:0] raw);
      logic [63:0] n;
      logic [63:0] odd_part;
      logic [63:0] x;
      logic [63:0] prev;
      int          twos;
      n = 64'(raw);
      if (n < 64'd2) return 1'b0;
      odd_part = n - 64'd1;
      twos     = 0;
      while (!odd_part[0] && twos < 64) begin
         twos++;
         odd_part = odd_part >> 1;
      end
      for (int i = 0; i < BASE_COUNT && i < BASE_LIST_LEN; i++) begin
         // a candidate that is itself a witness base is prime on the spot
         if (64'(TRIAL_BASES[i]) == n) return 1'b1;
         x = mod_power(64'(TRIAL_BASES[i]), odd_part, n);
         if (x != 64'd1) begin
            for (int k = 1; k <= twos; k++) begin
               prev = x;
               x    = mod_product(prev, prev, n);
               if (x == 64'd1) begin
                  // a nontrivial square root of one proves the candidate composite
                  if (prev != n - 64'd1) return 1'b0;
                  break;
               end
            end
            if (x != 64'd1) return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------------------

   function automatic logic [63:0] random_bits(input int width);
      logic [63:0] v;
      v = {$urandom, $urandom};
      if (width < 64) v = v & ((64'd1 << width) - 64'd1);
      return v;
   endfunction

   // first odd prime at or above start, walking odd values; clamped at LARGEST_PRIME
   function automatic logic [63:0] prime_at_or_above(input logic [63:0] start);
      logic [63:0] v;
      v = start | 64'd1;
      if (v > LARGEST_PRIME) v = LARGEST_PRIME;
      while (!primality_verdict(v)) v = v + 64'd2;
      return v;
   endfunction

   task automatic queue_candidate(input logic [63:0] value, input logic drain_first);
      candidate_word_type w;
      w.value       = value[VALUE_WIDTH-1:0];
      w.drain_first = drain_first;
      candidate_q.push_back(w);
   endtask

   // ---------------------------------------------------------------------------------------
   // driver: bursts of words with random gaps; a word marked drain_first waits until the
   // block has returned every verdict it owes
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin : word_driver
      logic               taken;
      logic               next_valid;
      candidate_word_type w;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else begin
         taken      = req_tvalid && req_tready;
         next_valid = req_tvalid && !req_tready;   // an offered word stays until taken
         if (taken) begin
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 6);
               case ($urandom_range(0, 7))
                  0, 1, 2: gap_left = 0;
                  7:       gap_left = $urandom_range(500, 4000);   // long enough to go idle
                  default: gap_left = $urandom_range(1, 40);
               endcase
            end
         end
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (candidate_q.size() != 0) begin
               // verdicts_due is registered and lags the handshake, so a word taken now also counts
               if (!(candidate_q[0].drain_first && (taken || verdicts_due != 0))) begin
                  w          = candidate_q.pop_front();
                  req_tdata  <= REQ_W'(w.value);
                  next_valid = 1'b1;
               end
            end
         end
         req_tvalid <= next_valid;
      end
   end

   // ---------------------------------------------------------------------------------------
   // monitor: predicts on each accepted candidate, checks each accepted verdict in order,
   // and drives the receiver's stall pattern
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin : word_monitor
      logic expected;
      int   delta;
      logic ready;
      if (reset) begin
         rsp_tready   <= 1'b0;
         verdicts_due <= 0;
      end else begin
         delta = 0;
         // check the returning word before adding a new expectation
         if (rsp_tvalid && rsp_tready) begin
            if (verdict_q.size() == 0) begin
               $error("is_prime word with no candidate outstanding: actual %0d", rsp_tdata[0]);
               mismatches++;
            end else begin
               expected = verdict_q.pop_front();
               delta--;
               if (rsp_tdata[0] !== expected) begin
                  $error("is_prime mismatch: expected %0d, actual %0d", expected, rsp_tdata[0]);
                  mismatches++;
               end
               if (rsp_tdata[RSP_W-1:1] !== '0) begin
                  $error("rsp_tdata padding mismatch: expected 0, actual 'h%0h",
                         rsp_tdata[RSP_W-1:1]);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            verdict_q.push_back(primality_verdict(req_tdata[VALUE_WIDTH-1:0]));
            delta++;
         end
         verdicts_due <= verdicts_due + delta;

         // receiver: mode changes at random intervals
         if (rx_mode_left == 0) begin
            rx_mode      = rx_mode_type'($urandom_range(0, 2));
            rx_mode_left = $urandom_range(500, 20000);
         end else begin
            rx_mode_left--;
         end
         if (stall_left > 0) begin
            stall_left--;
            ready = 1'b0;
         end else begin
            ready = 1'b1;
            case (rx_mode)
               RX_JITTER: if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 8);
               RX_STALL:  if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(20, 300);
               default:   stall_left = 0;
            endcase
         end
         rsp_tready <= ready;
      end
   end

   // watchdog against a hang
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // stimulus and end of run
   // ---------------------------------------------------------------------------------------
   initial begin : stimulus
      logic [63:0] corners [23];
      logic [63:0] p;
      logic [63:0] q;
      logic [63:0] value;
      int          pick;

      // directed: trivial values, witness bases, classic pseudoprimes, edges of the range
      corners = '{
         64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd9, 64'd23, 64'd29, 64'd31,
         64'd561,                       // carmichael number
         64'd2047,                      // strong pseudoprime to base 2
         64'd65537,                     // n-1 is a power of two
         64'd1000000007,
         64'd3215031751,                // strong pseudoprime to bases 2, 3, 5, 7
         64'd4294967291,                // largest 32-bit prime
         64'd4294967297,                // 2^32+1, composite
         64'd3825123056546413051,       // strong pseudoprime to bases 2 through 23
         64'h8000_0000_0000_001D,       // just above 2^63
         LARGEST_PRIME,
         64'd18446744030759878681,      // square of the largest 32-bit prime
         64'hFFFF_FFFF_FFFF_FFFF,
         64'hAAAA_AAAA_AAAA_AAAA,
         64'h5555_5555_5555_5555
      };
      foreach (corners[i]) queue_candidate(corners[i], (i % 8) == 7);

      // random: mostly small and mid-size values, a few full-width primes, which are the slow case
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            value = random_bits($urandom_range(2, 20));
         end else if (pick < 50) begin
            value = prime_at_or_above(random_bits($urandom_range(2, 20)));
         end else if (pick < 60) begin
            // product of two primes: composite with no small factor in general
            p     = prime_at_or_above(random_bits($urandom_range(3, 31)));
            q     = prime_at_or_above(random_bits($urandom_range(3, 31)));
            value = p * q;
         end else if (pick < 75) begin
            value = random_bits($urandom_range(21, 40));
         end else if (pick < 85) begin
            value = random_bits(64);
         end else if (pick < 95) begin
            value = prime_at_or_above(random_bits($urandom_range(21, 40)));
         end else begin
            value = prime_at_or_above({1'b1, 63'(random_bits(63))});
         end
         // the first random word always waits for the block to drain
         queue_candidate(value, i == 0 || $urandom_range(0, 19) == 0);
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // sampled on the falling edge so the queues and handshakes have settled
      do @(negedge clock);
      while (candidate_q.size() != 0 || req_tvalid || verdict_q.size() != 0);

      // idle tail to catch any stray verdict word
      repeat (200) @(posedge clock);

      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

### filelist.f
sv/mrpt_pkg.sv
sv/mrpt_mulmod.sv
sv/mrpt_datapath.sv
sv/mrpt_ctrl.sv
sv/miller_rabin_prime_test.sv
sv/mrpt_checker.sv
sim/miller_rabin_prime_test_tb.sv
